// ===== hdl/snw_pkg.sv =====
// shared types, constants and helpers of the scrolling note waterfall
`timescale 1ns / 1ps

package snw_pkg;

    // frame geometry and channel count
    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 240;
    localparam int NUM_CHANNELS = 8;

    // derived sizes
    localparam int STORE_SIZE  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_SIZE);
    localparam int X_W         = $clog2(FRAME_WIDTH);
    localparam int Y_W         = (FRAME_HEIGHT > 2) ? $clog2(FRAME_HEIGHT) : 1;
    localparam int BOTTOM_BASE = (FRAME_HEIGHT - 1) * FRAME_WIDTH;

    // channel inputs are fixed at eight, only the first NUM_CHANNELS are painted
    localparam int CH_MAX = 8;
    localparam int CH_W   = 3;
    localparam int NOTE_W = 8;
    localparam int P_W    = 10;

    // pixel constants
    localparam logic [31:0] BG_RESET   = 32'hA000_0000;
    localparam logic [31:0] THIRD_MARK = 32'h2000_0000;

    localparam logic [31:0] PALETTE [CH_MAX] = '{
        32'hEFFF_0000, 32'hEF00_FF00, 32'hEF00_00FF, 32'hEFFF_FF00,
        32'hEFFF_00FF, 32'hEF00_FFFF, 32'hEFFF_FFFF, 32'hEFFF_FFFF
    };

    // configuration register indexes
    localparam logic [7:0] CFG_BACKGROUND = 8'd0;
    localparam logic [7:0] CFG_FADE_LIMIT = 8'd1;
    localparam logic [7:0] CFG_FADE_STEP  = 8'd2;
    localparam logic [7:0] CFG_NOTE_ALPHA = 8'd3;

    // configuration reset values
    localparam logic [31:0] RST_BACKGROUND = BG_RESET;
    localparam logic [7:0]  RST_FADE_LIMIT = 8'd60;
    localparam logic [7:0]  RST_FADE_STEP  = 8'd5;
    localparam logic [7:0]  RST_NOTE_ALPHA = 8'hCF;

    // item function codes
    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    typedef struct packed {
        logic [31:0] background;
        logic [7:0]  fade_limit;
        logic [7:0]  fade_step;
        logic [7:0]  note_alpha;
    } t_cfg;

    typedef logic [CH_MAX-1:0][NOTE_W-1:0] t_notes;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCROLL,
        S_DRAIN,
        S_FILL,
        S_PAINT_CHK,
        S_PAINT_RD,
        S_PAINT_W0,
        S_PAINT_W1,
        S_PAINT_W2,
        S_RD_ADDR,
        S_RD_ISSUE,
        S_RD_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_CLR_STEP,
        OP_SCR_STEP,
        OP_FILL_START,
        OP_FILL_STEP,
        OP_PAINT_LOAD,
        OP_PAINT_SKIP,
        OP_PAINT_RD,
        OP_PAINT_W0,
        OP_PAINT_W1,
        OP_PAINT_W2,
        OP_RD_LOAD,
        OP_RD_ISSUE,
        OP_OUT_LOAD
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic scr_last;
        logic fill_last;
        logic paint_ok;
        logic ch_last;
        logic out_free;
    } t_status;

    // bar start column: floor(note * 5 / 2)
    function automatic logic [P_W-1:0] note_pos(input logic [NOTE_W-1:0] note);
        logic [NOTE_W+2:0] times5;
        times5 = {1'b0, note, 2'b00} + {3'b000, note};
        return times5[NOTE_W+2:1];
    endfunction

endpackage

// ===== hdl/snw_ctrl.sv =====
// sequencer for clear, scroll, row fill, note painting and pixel read
`timescale 1ns / 1ps

module snw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_func,
    output logic             o_in_ready,
    input  snw_pkg::t_status i_status,
    output snw_pkg::t_cmd    o_cmd
);

    snw_pkg::t_state r_state;
    snw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= snw_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = snw_pkg::OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            snw_pkg::S_CLEAR: begin
                o_cmd.op = snw_pkg::OP_CLR_STEP;
                if (i_status.clr_last) begin
                    n_state = snw_pkg::S_IDLE;
                end
            end
            snw_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = snw_pkg::OP_CAPTURE;
                    n_state  = (i_func == snw_pkg::FUNC_READ) ? snw_pkg::S_RD_ADDR
                                                              : snw_pkg::S_SCROLL;
                end
            end
            snw_pkg::S_SCROLL: begin
                o_cmd.op = snw_pkg::OP_SCR_STEP;
                if (i_status.scr_last) begin
                    n_state = snw_pkg::S_DRAIN;
                end
            end
            snw_pkg::S_DRAIN: begin
                o_cmd.op = snw_pkg::OP_FILL_START;
                n_state  = snw_pkg::S_FILL;
            end
            snw_pkg::S_FILL: begin
                o_cmd.op = snw_pkg::OP_FILL_STEP;
                if (i_status.fill_last) begin
                    n_state = snw_pkg::S_PAINT_CHK;
                end
            end
            snw_pkg::S_PAINT_CHK: begin
                if (i_status.paint_ok) begin
                    o_cmd.op = snw_pkg::OP_PAINT_LOAD;
                    n_state  = snw_pkg::S_PAINT_RD;
                end else begin
                    o_cmd.op = snw_pkg::OP_PAINT_SKIP;
                    if (i_status.ch_last) begin
                        n_state = snw_pkg::S_IDLE;
                    end
                end
            end
            snw_pkg::S_PAINT_RD: begin
                o_cmd.op = snw_pkg::OP_PAINT_RD;
                n_state  = snw_pkg::S_PAINT_W0;
            end
            snw_pkg::S_PAINT_W0: begin
                o_cmd.op = snw_pkg::OP_PAINT_W0;
                n_state  = snw_pkg::S_PAINT_W1;
            end
            snw_pkg::S_PAINT_W1: begin
                o_cmd.op = snw_pkg::OP_PAINT_W1;
                n_state  = snw_pkg::S_PAINT_W2;
            end
            snw_pkg::S_PAINT_W2: begin
                o_cmd.op = snw_pkg::OP_PAINT_W2;
                n_state  = i_status.ch_last ? snw_pkg::S_IDLE : snw_pkg::S_PAINT_CHK;
            end
            snw_pkg::S_RD_ADDR: begin
                o_cmd.op = snw_pkg::OP_RD_LOAD;
                n_state  = snw_pkg::S_RD_ISSUE;
            end
            snw_pkg::S_RD_ISSUE: begin
                o_cmd.op = snw_pkg::OP_RD_ISSUE;
                n_state  = snw_pkg::S_RD_OUT;
            end
            snw_pkg::S_RD_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.op = snw_pkg::OP_OUT_LOAD;
                    n_state  = snw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = snw_pkg::S_IDLE;
            end
        endcase
    end

    // an accepted item always takes the sequencer out of idle
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("sequencer stayed ready after taking an item");

    // the clearing pass after reset runs to its end before any item is taken
    a_clear_before_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == snw_pkg::S_CLEAR && !i_status.clr_last) |=> !o_in_ready)
        else $error("item port opened during the clearing pass");

endmodule

// ===== hdl/snw_dp.sv =====
// frame store, address counters, fade and paint arithmetic, result register
`timescale 1ns / 1ps

module snw_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  snw_pkg::t_cmd             i_cmd,
    output snw_pkg::t_status          o_status,
    input  snw_pkg::t_cfg             i_cfg,
    input  logic [snw_pkg::X_W-1:0]   i_unused_guard,
    input  snw_pkg::t_notes           i_notes,
    input  logic [8:0]                i_read_x,
    input  logic [7:0]                i_read_y,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [31:0]               o_pixel_value
);

    logic [31:0] mem [snw_pkg::STORE_SIZE];

    logic [snw_pkg::ADDR_W-1:0] r_addr;
    logic [snw_pkg::ADDR_W-1:0] r_pwa;
    logic                       r_pv;
    logic                       r_pfade;
    logic [snw_pkg::X_W-1:0]    r_x;
    logic [snw_pkg::Y_W-1:0]    r_y;
    logic                       r_pass;
    logic [snw_pkg::CH_W-1:0]   r_ch;
    logic                       r_rok;
    logic [31:0]                r_q;
    logic [31:0]                r_c;
    logic                       r_out_vld;
    logic [31:0]                r_pixel;
    snw_pkg::t_notes            r_notes;
    logic [8:0]                 r_rx;
    logic [7:0]                 r_ry;

    logic                       wr_en;
    logic [snw_pkg::ADDR_W-1:0] wr_addr;
    logic [31:0]                wr_data;
    logic                       rd_en;
    logic [31:0]                faded;
    logic [31:0]                paint_c;
    logic [snw_pkg::P_W-1:0]    pos;
    logic [7:0]                 alpha;
    logic                       x_end;
    logic [31:0]                rd_lin;

    assign x_end = (r_x == snw_pkg::X_W'(snw_pkg::FRAME_WIDTH - 1));
    assign alpha = r_q[31:24];
    assign pos   = snw_pkg::note_pos(r_notes[r_ch]);

    // fade of a pixel moving up out of a row near the top
    always_comb begin
        faded = r_q;
        if (r_pfade && (alpha >= i_cfg.fade_step)) begin
            faded = {alpha - i_cfg.fade_step, r_q[23:0]};
        end
    end

    assign paint_c = (r_q + snw_pkg::PALETTE[r_ch]) | {i_cfg.note_alpha, 24'h0};
    assign rd_lin  = 32'(r_ry) * 32'(snw_pkg::FRAME_WIDTH) + 32'(r_rx);

    // single write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_data = i_cfg.background;
        if (r_pv) begin
            wr_en   = 1'b1;
            wr_addr = r_pwa;
            wr_data = faded;
        end else begin
            case (i_cmd.op)
                snw_pkg::OP_CLR_STEP: begin
                    wr_en   = 1'b1;
                    wr_data = snw_pkg::BG_RESET;
                end
                snw_pkg::OP_FILL_STEP: begin
                    wr_en = 1'b1;
                end
                snw_pkg::OP_PAINT_W0: begin
                    wr_en   = 1'b1;
                    wr_data = paint_c;
                end
                snw_pkg::OP_PAINT_W1: begin
                    wr_en   = 1'b1;
                    wr_data = r_c;
                end
                snw_pkg::OP_PAINT_W2: begin
                    wr_en   = 1'b1;
                    wr_data = r_c | snw_pkg::THIRD_MARK;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    assign rd_en = (i_cmd.op == snw_pkg::OP_SCR_STEP) || (i_cmd.op == snw_pkg::OP_PAINT_RD)
                || ((i_cmd.op == snw_pkg::OP_RD_ISSUE) && r_rok);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_q <= mem[r_addr];
        end
    end

    // counters and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_pv      <= 1'b0;
            r_ch      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_pv <= 1'b0;
            if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            case (i_cmd.op)
                snw_pkg::OP_CLR_STEP: begin
                    r_addr <= r_addr + 1'b1;
                end
                snw_pkg::OP_CAPTURE: begin
                    r_addr <= snw_pkg::ADDR_W'(snw_pkg::FRAME_WIDTH);
                    r_x    <= '0;
                    r_y    <= snw_pkg::Y_W'(1);
                    r_ch   <= '0;
                end
                snw_pkg::OP_SCR_STEP: begin
                    r_pv    <= 1'b1;
                    r_pwa   <= r_addr - snw_pkg::ADDR_W'(snw_pkg::FRAME_WIDTH);
                    r_pfade <= (32'(r_y) < 32'(i_cfg.fade_limit));
                    r_addr  <= r_addr + 1'b1;
                    if (x_end) begin
                        r_x <= '0;
                        r_y <= r_y + 1'b1;
                    end else begin
                        r_x <= r_x + 1'b1;
                    end
                end
                snw_pkg::OP_FILL_START: begin
                    r_addr <= snw_pkg::ADDR_W'(snw_pkg::BOTTOM_BASE);
                    r_x    <= '0;
                    r_pass <= 1'b0;
                end
                snw_pkg::OP_FILL_STEP: begin
                    if (x_end) begin
                        r_x    <= '0;
                        r_addr <= '0;
                        r_pass <= 1'b1;
                    end else begin
                        r_x    <= r_x + 1'b1;
                        r_addr <= r_addr + 1'b1;
                    end
                end
                snw_pkg::OP_PAINT_LOAD: begin
                    r_addr <= snw_pkg::ADDR_W'(snw_pkg::BOTTOM_BASE) + snw_pkg::ADDR_W'(pos);
                end
                snw_pkg::OP_PAINT_SKIP: begin
                    r_ch <= r_ch + 1'b1;
                end
                snw_pkg::OP_PAINT_W0: begin
                    r_c    <= paint_c;
                    r_addr <= r_addr + 1'b1;
                end
                snw_pkg::OP_PAINT_W1: begin
                    r_addr <= r_addr + 1'b1;
                end
                snw_pkg::OP_PAINT_W2: begin
                    r_ch <= r_ch + 1'b1;
                end
                snw_pkg::OP_RD_LOAD: begin
                    r_addr <= rd_lin[snw_pkg::ADDR_W-1:0];
                    r_rok  <= (32'(r_rx) < 32'(snw_pkg::FRAME_WIDTH))
                           && (32'(r_ry) < 32'(snw_pkg::FRAME_HEIGHT));
                end
                snw_pkg::OP_OUT_LOAD: begin
                    r_out_vld <= 1'b1;
                    r_pixel   <= r_rok ? r_q : 32'h0;
                end
                default: begin
                    r_pv <= 1'b0;
                end
            endcase
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == snw_pkg::OP_CAPTURE) begin
            r_notes <= i_notes;
            r_rx    <= i_read_x;
            r_ry    <= i_read_y;
        end
    end

    assign o_status.clr_last  = (r_addr == snw_pkg::ADDR_W'(snw_pkg::STORE_SIZE - 1));
    assign o_status.scr_last  = (r_addr == snw_pkg::ADDR_W'(snw_pkg::STORE_SIZE - 1));
    assign o_status.fill_last = r_pass && x_end;
    assign o_status.paint_ok  = (r_notes[r_ch] != '0)
                             && ((32'(pos) + 32'd2) < 32'(snw_pkg::FRAME_WIDTH));
    assign o_status.ch_last   = (r_ch == snw_pkg::CH_W'(snw_pkg::NUM_CHANNELS - 1));
    assign o_status.out_free  = !r_out_vld || i_out_ready;

    assign o_out_valid   = r_out_vld;
    assign o_pixel_value = r_pixel;

    // a scroll write always comes in the cycle after its own read
    a_scroll_write_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> ($past(i_cmd.op) == snw_pkg::OP_SCR_STEP))
        else $error("scroll write without a matching read");

    // note marks land on the bottom row only
    a_paint_bottom_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd.op == snw_pkg::OP_PAINT_W0) || (i_cmd.op == snw_pkg::OP_PAINT_W1)
         || (i_cmd.op == snw_pkg::OP_PAINT_W2))
        |-> (32'(r_addr) >= 32'(snw_pkg::BOTTOM_BASE)))
        else $error("note mark written outside the bottom row");

    // a result is never loaded over one that is still waiting
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == snw_pkg::OP_OUT_LOAD) |-> (!r_out_vld || i_out_ready))
        else $error("result register overwritten");

    // guard input carries the column counter width and must match it
    a_guard_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == snw_pkg::OP_CAPTURE) |=> (r_x == i_unused_guard))
        else $error("column counter not cleared on capture");

endmodule

// ===== hdl/scrolling_note_waterfall_core.sv =====
// top level of the scrolling note waterfall: config registers, sequencer and datapath
`timescale 1ns / 1ps

//  channel   direction  handshake                  payload
//  item in   input      i_in_valid / o_in_ready    i_func, i_note_ch0..7, i_read_x, i_read_y
//  result    output     o_out_valid / i_out_ready  o_pixel_value
//  config    input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  update item: every row scrolls up by one, the bottom and top rows are filled with the
//    background, then each channel is checked and each painted one gets its mark;
//    the single frame store write port moves one pixel a cycle
//  read item: the address is formed, the store is read and the result is loaded once the
//    result register is free; the next item is taken after that
//  reset: a clearing pass fills the store with the background reset value; items wait,
//    config writes are taken throughout
//  a waiting result holds the sequencer only at the end of a read; until the next read
//    gets there the item port stays open, and config is always ready

module scrolling_note_waterfall_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item in
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [7:0]  i_note_ch0,
    input  logic [7:0]  i_note_ch1,
    input  logic [7:0]  i_note_ch2,
    input  logic [7:0]  i_note_ch3,
    input  logic [7:0]  i_note_ch4,
    input  logic [7:0]  i_note_ch5,
    input  logic [7:0]  i_note_ch6,
    input  logic [7:0]  i_note_ch7,
    input  logic [8:0]  i_read_x,
    input  logic [7:0]  i_read_y,
    // result out
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_pixel_value,
    // config writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    snw_pkg::t_cfg    r_cfg;
    snw_pkg::t_cmd    cmd;
    snw_pkg::t_status status;
    snw_pkg::t_notes  notes;

    // config is a plain register file, each write is registered
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.background <= snw_pkg::RST_BACKGROUND;
            r_cfg.fade_limit <= snw_pkg::RST_FADE_LIMIT;
            r_cfg.fade_step  <= snw_pkg::RST_FADE_STEP;
            r_cfg.note_alpha <= snw_pkg::RST_NOTE_ALPHA;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                snw_pkg::CFG_BACKGROUND: r_cfg.background <= i_cfg_data;
                snw_pkg::CFG_FADE_LIMIT: r_cfg.fade_limit <= i_cfg_data[7:0];
                snw_pkg::CFG_FADE_STEP:  r_cfg.fade_step  <= i_cfg_data[7:0];
                snw_pkg::CFG_NOTE_ALPHA: r_cfg.note_alpha <= i_cfg_data[7:0];
                default: begin
                    // indexes past the register list are dropped
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // channel notes gathered into one vector, channel 0 in the lowest slot
    assign notes[0] = i_note_ch0;
    assign notes[1] = i_note_ch1;
    assign notes[2] = i_note_ch2;
    assign notes[3] = i_note_ch3;
    assign notes[4] = i_note_ch4;
    assign notes[5] = i_note_ch5;
    assign notes[6] = i_note_ch6;
    assign notes[7] = i_note_ch7;

    snw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    snw_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg          (r_cfg),
        .i_unused_guard ('0),
        .i_notes        (notes),
        .i_read_x       (i_read_x),
        .i_read_y       (i_read_y),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_value  (o_pixel_value)
    );

endmodule

// ===== dv/scrolling_note_waterfall_core_test.sv =====
// self-checking testbench of the scrolling note waterfall core
`timescale 1ns / 1ps

module scrolling_note_waterfall_core_test;

    // settle long enough to cover a silent frame update
    localparam int UPDATE_SETTLE = 80000;
    localparam int END_SETTLE    = 20;
    localparam int PHASE_ITEMS   = 19;

    // unused register indexes, writes there must change nothing
    localparam logic [7:0] CFG_SPARE_LO = 8'd4;
    localparam logic [7:0] CFG_SPARE_HI = 8'hFF;

    // per-channel mark colors
    localparam logic [31:0] MARK_COLOR [8] = '{
        32'hEFFF_0000, 32'hEF00_FF00, 32'hEF00_00FF, 32'hEFFF_FF00,
        32'hEFFF_00FF, 32'hEF00_FFFF, 32'hEFFF_FFFF, 32'hEFFF_FFFF
    };
    localparam snw_pkg::t_notes NO_NOTES = '0;

    typedef struct {
        logic            func;
        snw_pkg::t_notes notes;     // byte i is channel i
        logic [8:0]      col;
        logic [7:0]      row;
        logic            fixed;     // result typed in the table
        logic [31:0]     want;
    } t_stim_row;

    // directed rows: reset contents, reads outside the frame, marks at the row edges,
    // stacked and skipped notes, then scrolling and fading of what was painted
    t_stim_row dir_rows [25] = '{
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd0, 8'd0, 1'b1, 32'hA000_0000},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd319, 8'd239, 1'b1, 32'hA000_0000},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd320, 8'd0, 1'b1, 32'h0},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd0, 8'd240, 1'b1, 32'h0},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd511, 8'd255, 1'b1, 32'h0},
        // ch7..ch0: last column, stacked on ch0, adjacent, silent, two skipped, edge
        '{snw_pkg::FUNC_UPDATE, {8'd127, 8'd1, 8'd2, 8'd0, 8'd255, 8'd128, 8'd127, 8'd1},
          9'd0, 8'd0, 1'b0, 32'h0},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd2, 8'd239, 1'b0, 32'h0},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd4, 8'd239, 1'b0, 32'h0},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd5, 8'd239, 1'b0, 32'h0},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd317, 8'd239, 1'b0, 32'h0},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd319, 8'd239, 1'b0, 32'h0},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd319, 8'd0, 1'b0, 32'h0},
        '{snw_pkg::FUNC_UPDATE, {8'd80, 8'd70, 8'd170, 8'd85, 8'd3, 8'd64, 8'd0, 8'd0},
          9'd0, 8'd0, 1'b0, 32'h0},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd2, 8'd238, 1'b0, 32'h0},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd160, 8'd239, 1'b0, 32'h0},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd7, 8'd239, 1'b0, 32'h0},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd212, 8'd239, 1'b0, 32'h0},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd100, 8'd120, 1'b0, 32'h0},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd100, 8'd1, 1'b0, 32'h0},
        '{snw_pkg::FUNC_UPDATE, NO_NOTES, 9'd0, 8'd0, 1'b0, 32'h0},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd3, 8'd237, 1'b0, 32'h0},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd318, 8'd237, 1'b0, 32'h0},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd0, 8'd239, 1'b0, 32'h0},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd256, 8'd58, 1'b0, 32'h0},
        '{snw_pkg::FUNC_READ, NO_NOTES, 9'd200, 8'd59, 1'b0, 32'h0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_func = snw_pkg::FUNC_UPDATE;
    logic [7:0]  i_note_ch0 = '0;
    logic [7:0]  i_note_ch1 = '0;
    logic [7:0]  i_note_ch2 = '0;
    logic [7:0]  i_note_ch3 = '0;
    logic [7:0]  i_note_ch4 = '0;
    logic [7:0]  i_note_ch5 = '0;
    logic [7:0]  i_note_ch6 = '0;
    logic [7:0]  i_note_ch7 = '0;
    logic [8:0]  i_read_x = '0;
    logic [7:0]  i_read_y = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_pixel_value;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    // predicted frame contents and register copies
    logic [31:0] frame_px [snw_pkg::STORE_SIZE];
    logic [31:0] cfg_bg;
    logic [7:0]  cfg_fade_limit;
    logic [7:0]  cfg_fade_step;
    logic [7:0]  cfg_note_alpha;

    logic [31:0] pending_pixels [$];   // pixels still owed by the block, oldest first
    int          mark_cols [$];        // recent mark columns, used to aim reads
    logic [31:0] got_want;
    logic        last_was_update = 1'b0;

    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    int err_count = 0;
    int n_updates = 0;
    int n_reads = 0;
    int n_outside = 0;
    int n_cfg = 0;
    int n_checked = 0;

    scrolling_note_waterfall_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_note_ch0    (i_note_ch0),
        .i_note_ch1    (i_note_ch1),
        .i_note_ch2    (i_note_ch2),
        .i_note_ch3    (i_note_ch3),
        .i_note_ch4    (i_note_ch4),
        .i_note_ch5    (i_note_ch5),
        .i_note_ch6    (i_note_ch6),
        .i_note_ch7    (i_note_ch7),
        .i_read_x      (i_read_x),
        .i_read_y      (i_read_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_value (o_pixel_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic void flag_error(input string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("%0t ns: %s", $time, msg);
        end
    endfunction

    // scroll up with fading near the top, clear top and bottom, paint the marks
    task automatic scroll_and_paint(input snw_pkg::t_notes nts);
        int x;
        int y;
        int ch;
        int pos;
        logic [31:0] px;
        logic [31:0] mark;
        for (y = 1; y < snw_pkg::FRAME_HEIGHT; y++) begin
            for (x = 0; x < snw_pkg::FRAME_WIDTH; x++) begin
                px = frame_px[y * snw_pkg::FRAME_WIDTH + x];
                if (y < int'(cfg_fade_limit) && px[31:24] >= cfg_fade_step) begin
                    px = px - {cfg_fade_step, 24'h0};
                end
                frame_px[(y - 1) * snw_pkg::FRAME_WIDTH + x] = px;
            end
        end
        for (x = 0; x < snw_pkg::FRAME_WIDTH; x++) begin
            frame_px[x] = cfg_bg;
            frame_px[(snw_pkg::FRAME_HEIGHT - 1) * snw_pkg::FRAME_WIDTH + x] = cfg_bg;
        end
        for (ch = 0; ch < snw_pkg::NUM_CHANNELS; ch++) begin
            pos = (int'(nts[ch]) * 5) / 2;
            if (nts[ch] != 8'd0 && pos + 2 < snw_pkg::FRAME_WIDTH) begin
                x = (snw_pkg::FRAME_HEIGHT - 1) * snw_pkg::FRAME_WIDTH + pos;
                mark = (frame_px[x] + MARK_COLOR[ch]) | {cfg_note_alpha, 24'h0};
                frame_px[x] = mark;
                frame_px[x + 1] = mark;
                frame_px[x + 2] = mark | 32'h2000_0000;
                mark_cols.push_back(pos);
                if (mark_cols.size() > 24) begin
                    void'(mark_cols.pop_front());
                end
            end
        end
    endtask

    function automatic logic [31:0] fetch_pixel(input logic [8:0] col, input logic [7:0] row);
        if (col >= snw_pkg::FRAME_WIDTH || row >= snw_pkg::FRAME_HEIGHT) begin
            return 32'h0;
        end
        return frame_px[int'(row) * snw_pkg::FRAME_WIDTH + int'(col)];
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input t_stim_row r);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_func     = r.func;
        i_note_ch0 = r.notes[0];
        i_note_ch1 = r.notes[1];
        i_note_ch2 = r.notes[2];
        i_note_ch3 = r.notes[3];
        i_note_ch4 = r.notes[4];
        i_note_ch5 = r.notes[5];
        i_note_ch6 = r.notes[6];
        i_note_ch7 = r.notes[7];
        i_read_x   = r.col;
        i_read_y   = r.row;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        if (r.func == snw_pkg::FUNC_UPDATE) begin
            scroll_and_paint(r.notes);
            n_updates++;
            last_was_update = 1'b1;
        end else begin
            pending_pixels.push_back(r.fixed ? r.want : fetch_pixel(r.col, r.row));
            n_reads++;
            if (r.col >= snw_pkg::FRAME_WIDTH || r.row >= snw_pkg::FRAME_HEIGHT) begin
                n_outside++;
            end
            last_was_update = 1'b0;
        end
        @(negedge i_clk);
    endtask

    // leaves i_cfg_valid high, the caller lowers it after the last write
    task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            snw_pkg::CFG_BACKGROUND: cfg_bg = data;
            snw_pkg::CFG_FADE_LIMIT: cfg_fade_limit = data[7:0];
            snw_pkg::CFG_FADE_STEP:  cfg_fade_step = data[7:0];
            snw_pkg::CFG_NOTE_ALPHA: cfg_note_alpha = data[7:0];
            default: ;
        endcase
        n_cfg++;
        @(negedge i_clk);
    endtask

    // upper bits of the byte registers carry junk that must be dropped
    task automatic set_config(input logic [31:0] bg, input logic [7:0] lim,
                              input logic [7:0] step, input logic [7:0] alpha);
        write_reg(snw_pkg::CFG_BACKGROUND, bg);
        write_reg(snw_pkg::CFG_FADE_LIMIT, {24'($urandom()), lim});
        write_reg(snw_pkg::CFG_FADE_STEP, {24'($urandom()), step});
        write_reg(snw_pkg::CFG_NOTE_ALPHA, {24'($urandom()), alpha});
        i_cfg_valid = 1'b0;
    endtask

    // block idle: nothing owed, and a silent update given time to finish
    task automatic settle_for_config();
        i_in_valid = 1'b0;
        while (pending_pixels.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (last_was_update ? UPDATE_SETTLE : 4) @(negedge i_clk);
    endtask

    task automatic make_update(output t_stim_row r);
        int ch;
        int pick;
        r = '{snw_pkg::FUNC_UPDATE, NO_NOTES, 9'd0, 8'd0, 1'b0, 32'h0};
        r.col = 9'($urandom());
        r.row = 8'($urandom());
        for (ch = 0; ch < 8; ch++) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                r.notes[ch] = 8'd0;
            end else if (pick < 40) begin
                r.notes[ch] = 8'($urandom_range(128, 255));
            end else if (pick < 50 && ch > 0) begin
                // same note as an earlier channel, so marks stack
                r.notes[ch] = r.notes[$urandom_range(0, ch - 1)];
            end else begin
                r.notes[ch] = 8'($urandom_range(1, 127));
            end
        end
    endtask

    // in-frame reads aim mostly at the freshly painted rows near the bottom
    task automatic make_read(output t_stim_row r);
        int pick;
        r = '{snw_pkg::FUNC_READ, snw_pkg::t_notes'({$urandom(), $urandom()}),
              9'd0, 8'd0, 1'b0, 32'h0};
        pick = $urandom_range(99);
        if (pick < 10) begin
            r.col = 9'($urandom_range(320, 511));
            r.row = 8'($urandom());
        end else if (pick < 20) begin
            r.col = 9'($urandom());
            r.row = 8'($urandom_range(240, 255));
        end else begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                r.row = 8'($urandom_range(226, 239));
            end else if (pick < 65) begin
                r.row = 8'($urandom_range(0, 2));
            end else begin
                r.row = 8'($urandom_range(0, 239));
            end
            if (mark_cols.size() != 0 && $urandom_range(99) < 60) begin
                r.col = 9'(mark_cols[$urandom_range(0, mark_cols.size() - 1)]
                           + $urandom_range(0, 2));
            end else begin
                r.col = 9'($urandom_range(0, 319));
            end
        end
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pixels.size() == 0) begin
                flag_error($sformatf("pixel %h arrived with nothing owed", o_pixel_value));
            end else begin
                got_want = pending_pixels.pop_front();
                n_checked++;
                if (o_pixel_value !== got_want) begin
                    flag_error($sformatf("pixel_value expected %h got %h",
                                         got_want, o_pixel_value));
                end
            end
        end
    end

    initial begin
        #12_000_000;
        $display("timed out");
        $display("scrolling_note_waterfall_core_test: errors");
        $finish;
    end

    initial begin
        t_stim_row r;
        int i;
        int ph;
        int k;
        int upd_a;
        int upd_b;

        cfg_bg         = 32'hA000_0000;
        cfg_fade_limit = 8'd60;
        cfg_fade_step  = 8'd5;
        cfg_note_alpha = 8'hCF;
        for (i = 0; i < snw_pkg::STORE_SIZE; i++) begin
            frame_px[i] = 32'hA000_0000;
        end

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // writes to indexes past the list must leave every register alone
        write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_HI, 32'h0000_0000);
        i_cfg_valid = 1'b0;

        // directed part, reset settings, no idling
        for (i = 0; i < $size(dir_rows); i++) begin
            send_item(dir_rows[i]);
        end
        i_in_valid = 1'b0;

        // random phases: each one new settings and its own idling pattern
        for (ph = 0; ph < 4; ph++) begin
            settle_for_config();
            case (ph)
                0: begin
                    snd_idle_pct = 0;
                    rcv_stall_pct = 0;
                    set_config(32'h0000_0000, 8'd0, 8'd0, 8'd0);
                end
                1: begin
                    snd_idle_pct = 72;
                    rcv_stall_pct = 0;
                    set_config(32'hFFFF_FFFF, 8'd240, 8'd255, 8'hFF);
                end
                2: begin
                    snd_idle_pct = 0;
                    rcv_stall_pct = 72;
                    set_config($urandom(), 8'd240, 8'($urandom_range(1, 40)),
                               8'($urandom()));
                end
                default: begin
                    snd_idle_pct = 24;
                    rcv_stall_pct = 24;
                    set_config($urandom(), 8'($urandom_range(0, 240)), 8'($urandom()),
                               8'($urandom()));
                end
            endcase
            // two updates per phase, always followed by reads of what they left
            upd_a = $urandom_range(0, 10);
            upd_b = $urandom_range(11, PHASE_ITEMS - 3);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 2 && k == 12) begin
                    // sender holds off until every owed pixel is back
                    i_in_valid = 1'b0;
                    while (pending_pixels.size() != 0) begin
                        @(negedge i_clk);
                    end
                end
                if (k == upd_a || k == upd_b) begin
                    make_update(r);
                end else begin
                    make_read(r);
                end
                send_item(r);
            end
            i_in_valid = 1'b0;
        end

        while (pending_pixels.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (END_SETTLE) @(negedge i_clk);
        if (pending_pixels.size() != 0) begin
            flag_error($sformatf("%0d pixels never arrived", pending_pixels.size()));
        end

        $display("covered %0d frame updates and %0d pixel reads, %0d of them off the frame",
                 n_updates, n_reads, n_outside);
        $display("%0d register writes over five settings, %0d pixels compared, %0d errors",
                 n_cfg, n_checked, err_count);
        if (err_count == 0) begin
            $display("scrolling_note_waterfall_core_test: clean");
        end else begin
            $display("scrolling_note_waterfall_core_test: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/snw_pkg.sv
hdl/snw_ctrl.sv
hdl/snw_dp.sv
hdl/scrolling_note_waterfall_core.sv
dv/scrolling_note_waterfall_core_test.sv
